@@ rtl/cpa_pkg.sv @@
// Shared types for the contiguous placement allocator.
`default_nettype none
package cpa_pkg;

  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_FRAG  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STRAT_FIRST = 2'd0,
    STRAT_BEST  = 2'd1,
    STRAT_NEXT  = 2'd2,
    STRAT_NONE  = 2'd3
  } strat_e;

  typedef struct packed {
    logic shift;
    logic tick;
    logic clear;
  } cell_ctl_t;

endpackage
`default_nettype wire

@@ rtl/cpa_cell.sv @@
// One unit cell of the rotating lifetime ring.
`default_nettype none
module cpa_cell #(
  parameter int LIFETIME_BITS = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire cpa_pkg::cell_ctl_t       ctl_i,
  input  wire logic [LIFETIME_BITS-1:0] d_i,
  output logic      [LIFETIME_BITS-1:0] q_o
);

  logic [LIFETIME_BITS-1:0] life_q, life_d;

  always_comb begin
    life_d = life_q;
    if (ctl_i.clear) begin
      life_d = '0;
    end else if (ctl_i.tick) begin
      if (life_q != '0) begin
        life_d = life_q - LIFETIME_BITS'(1);
      end
    end else if (ctl_i.shift) begin
      life_d = d_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      life_q <= '0;
    end else begin
      life_q <= life_d;
    end
  end

  assign q_o = life_q;

endmodule
`default_nettype wire

@@ rtl/contiguous_placement_allocator.sv @@
// Top level: ring of unit cells plus the run-scanning sequencer.
//
// Channel  | Direction | Ports                                        | Transfer
// command  | in        | start_i, busy_o, kind_i .. fragment_limit_i  | start_i & !busy_o
// result   | out       | valid_o, placed_o, runs_probed_o, fragment_total_o | valid_o
//
// Tick, clear, zero request and unknown strategy: valid_o is high in the cycle right
// after the transfer edge.
// Fragment query and failed allocation: the ring is first shifted to the scan origin, then
// every unit is scanned past the head cell; valid_o rises after the end state.
// Placed allocation: a full write pass around the ring follows the scan; the ring rotates
// one unit per cycle past the head cell.
// Reset clears all cells at once; results cannot be stalled, busy_o holds off commands.
`default_nettype none
module contiguous_placement_allocator #(
  parameter int UNIT_COUNT    = 256,
  parameter int LIFETIME_BITS = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  output logic            busy_o,
  input  wire logic [1:0] kind_i,
  input  wire logic [1:0] strategy_i,
  input  wire logic [8:0] request_units_i,
  input  wire logic [7:0] lifetime_i,
  input  wire logic [8:0] fragment_limit_i,
  output logic            valid_o,
  output logic            placed_o,
  output logic [7:0]      runs_probed_o,
  output logic [7:0]      fragment_total_o
);

  localparam int PW = (UNIT_COUNT > 1) ? $clog2(UNIT_COUNT) : 1;
  localparam int LW = $clog2(UNIT_COUNT + 1);
  localparam int CW = ((LW > 9) ? LW : 9) + 1;
  localparam logic [PW-1:0] LAST = PW'(UNIT_COUNT - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ALIGN = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_END   = 3'd3;
  localparam logic [2:0] ST_WRITE = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [PW-1:0] pos_q, pos_d, k_q, k_d, resume_q, resume_d, target_q, target_d;
  logic [PW-1:0] start_q, start_d, best_start_q, best_start_d;
  logic [LW-1:0] len_q, len_d, best_len_q, best_len_d;
  logic        found_q, found_d;
  logic [7:0]  runs_q, runs_d, frag_q, frag_d;
  logic [1:0]  kind_q, kind_d, strat_q, strat_d;
  logic [8:0]  req_q, req_d, limit_q, limit_d;
  logic [LIFETIME_BITS-1:0] life_q, life_d;
  logic        valid_q, valid_d, placed_q, placed_d;
  logic [7:0]  out_runs_q, out_runs_d, out_frag_q, out_frag_d;

  cpa_pkg::cell_ctl_t ctl;
  logic [LIFETIME_BITS-1:0] cell_q [UNIT_COUNT];
  logic [LIFETIME_BITS-1:0] tail_d;
  logic head_free, accept, in_range;
  logic [31:0] life_ext;
  logic [CW-1:0] len_c, req_c, best_c, lim_c, end_c, pos_c, fin_len;

  assign accept    = start_i && !busy_o;
  assign head_free = (cell_q[0] == '0);
  assign life_ext  = {24'b0, lifetime_i};
  assign len_c     = CW'(len_q);
  assign req_c     = CW'(req_q);
  assign best_c    = CW'(best_len_q);
  assign lim_c     = CW'(limit_q);
  assign pos_c     = CW'(pos_q);
  assign end_c     = CW'(start_q) + req_c;
  assign in_range  = (pos_c >= CW'(start_q)) && (pos_c < end_c);
  assign fin_len   = CW'(best_start_q) + req_c;
  assign tail_d    = (state_q == ST_WRITE && in_range) ? life_q : cell_q[0];

  for (genvar i = 0; i < UNIT_COUNT; i++) begin : g_cell
    cpa_cell #(.LIFETIME_BITS(LIFETIME_BITS)) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctl_i (ctl),
      .d_i   ((i == UNIT_COUNT - 1) ? tail_d : cell_q[(i + 1) % UNIT_COUNT]),
      .q_o   (cell_q[i])
    );
  end

  always_comb begin
    state_d = state_q;   pos_d = pos_q;     k_d = k_q;         resume_d = resume_q;
    target_d = target_q; start_d = start_q; best_start_d = best_start_q;
    len_d = len_q;       best_len_d = best_len_q; found_d = found_q;
    runs_d = runs_q;     frag_d = frag_q;   kind_d = kind_q;   strat_d = strat_q;
    req_d = req_q;       limit_d = limit_q; life_d = life_q;
    valid_d = 1'b0;      placed_d = placed_q;
    out_runs_d = out_runs_q; out_frag_d = out_frag_q;
    ctl = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          kind_d  = kind_i;
          strat_d = strategy_i;
          req_d   = request_units_i;
          limit_d = fragment_limit_i;
          life_d  = life_ext[LIFETIME_BITS-1:0];
          target_d = (strategy_i == cpa_pkg::STRAT_NEXT && kind_i == cpa_pkg::KIND_ALLOC)
                     ? resume_q : '0;
          placed_d = 1'b0; out_runs_d = '0; out_frag_d = '0;
          case (kind_i)
            cpa_pkg::KIND_TICK:  begin ctl.tick = 1'b1;  valid_d = 1'b1; end
            cpa_pkg::KIND_CLEAR: begin ctl.clear = 1'b1; valid_d = 1'b1; end
            cpa_pkg::KIND_FRAG:  state_d = ST_ALIGN;
            default: begin
              if (request_units_i == '0 || strategy_i == cpa_pkg::STRAT_NONE) begin
                valid_d = 1'b1;
              end else begin
                state_d = ST_ALIGN;
              end
            end
          endcase
        end
      end
      ST_ALIGN: begin
        k_d = '0; len_d = '0; best_len_d = '0; found_d = 1'b0;
        runs_d = '0; frag_d = '0; start_d = '0; best_start_d = '0;
        if (pos_q == target_q) begin
          state_d = ST_SCAN;
        end else begin
          ctl.shift = 1'b1;
          pos_d = (pos_q == LAST) ? '0 : pos_q + PW'(1);
        end
      end
      ST_SCAN: begin
        ctl.shift = 1'b1;
        pos_d = (pos_q == LAST) ? '0 : pos_q + PW'(1);
        k_d = k_q + PW'(1);
        if (k_q == LAST) state_d = ST_END;
        if (kind_q == cpa_pkg::KIND_FRAG || strat_q == cpa_pkg::STRAT_BEST) begin
          if (head_free) begin
            if (len_q == '0) begin
              start_d = pos_q;
              if (runs_q != 8'hFF) runs_d = runs_q + 8'd1;
            end
            len_d = len_q + LW'(1);
          end else begin
            if (len_q != '0 && len_c <= lim_c && frag_q != 8'hFF) frag_d = frag_q + 8'd1;
            if (len_c >= req_c && (!found_q || len_c < best_c)) begin
              found_d = 1'b1; best_len_d = len_q; best_start_d = start_q;
            end
            len_d = '0;
          end
        end else if (!found_q) begin
          if (head_free) begin
            if (len_q == '0 || k_q == '0 || pos_q == '0) begin
              start_d = pos_q;
              best_start_d = pos_q;
              if (runs_q != 8'hFF) runs_d = runs_q + 8'd1;
              len_d = LW'(1);
              if (req_c <= CW'(1)) found_d = 1'b1;
            end else begin
              len_d = len_q + LW'(1);
              if (len_c + CW'(1) >= req_c) found_d = 1'b1;
            end
          end else begin
            len_d = '0;
          end
        end
      end
      ST_END: begin
        if (kind_q == cpa_pkg::KIND_FRAG) begin
          out_frag_d = frag_q;
          if (len_q != '0 && len_c <= lim_c && frag_q != 8'hFF) out_frag_d = frag_q + 8'd1;
          valid_d = 1'b1;
          state_d = ST_IDLE;
        end else begin
          found_d = found_q;
          start_d = best_start_q;
          if (strat_q == cpa_pkg::STRAT_BEST && len_c >= req_c &&
              (!found_q || len_c < best_c)) begin
            found_d = 1'b1; start_d = start_q;
          end
          out_runs_d = runs_q;
          k_d = '0;
          if (found_d) begin
            state_d = ST_WRITE;
            if (strat_q == cpa_pkg::STRAT_NEXT) begin
              resume_d = (fin_len >= CW'(UNIT_COUNT)) ? '0 : fin_len[PW-1:0];
            end
          end else begin
            placed_d = 1'b0;
            valid_d = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      ST_WRITE: begin
        ctl.shift = 1'b1;
        pos_d = (pos_q == LAST) ? '0 : pos_q + PW'(1);
        k_d = k_q + PW'(1);
        if (k_q == LAST) begin
          placed_d = 1'b1;
          valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q <= '0;
      resume_q <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q <= pos_d;
      resume_q <= resume_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d; target_q <= target_d; start_q <= start_d; best_start_q <= best_start_d;
    len_q <= len_d; best_len_q <= best_len_d; found_q <= found_d;
    runs_q <= runs_d; frag_q <= frag_d; kind_q <= kind_d; strat_q <= strat_d;
    req_q <= req_d; limit_q <= limit_d; life_q <= life_d;
    placed_q <= placed_d; out_runs_q <= out_runs_d; out_frag_q <= out_frag_d;
  end

  assign busy_o           = (state_q != ST_IDLE);
  assign valid_o          = valid_q;
  assign placed_o         = placed_q;
  assign runs_probed_o    = out_runs_q;
  assign fragment_total_o = out_frag_q;

  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy_o) else $error("result while busy");
  a_busy_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i)) else $error("busy without command");
  a_write_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WRITE |-> kind_q == cpa_pkg::KIND_ALLOC && found_q)
    else $error("write pass without placement");
  a_scan_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ALIGN && state_d == ST_SCAN) |=> pos_q == target_q)
    else $error("scan origin mismatch");

endmodule
`default_nettype wire

@@ dv/tb_contiguous_placement_allocator.sv @@
// Self-checking testbench for the contiguous placement allocator.
`default_nettype none
module tb_contiguous_placement_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int UNITS = 256;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct {
    cpa_pkg::kind_e  kind;
    cpa_pkg::strat_e strat;
    logic [8:0] req;
    logic [7:0] life;
    logic [8:0] limit;
    bit        drain;
  } cmd_t;

  typedef struct {
    logic       placed;
    logic [7:0] probed;
    logic [7:0] frags;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic [1:0] kind_i = '0;
  logic [1:0] strategy_i = '0;
  logic [8:0] request_units_i = '0;
  logic [7:0] lifetime_i = '0;
  logic [8:0] fragment_limit_i = '0;
  logic valid_o, placed_o;
  logic [7:0] runs_probed_o, fragment_total_o;

  contiguous_placement_allocator DUT (.*);

  always #5 clk_i = ~clk_i;

  cmd_t     pending_cmds[$];
  outcome_t expected_outcomes[$];
  logic [7:0] cells[UNITS];
  int unsigned resume_pos;
  int errors = 0;
  int cycles = 0;
  int gap = 0;
  bit stim_done = 0;
  bit quiet = 0;

  function automatic logic [7:0] sat8(int unsigned v);
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic bit scan_fit(int unsigned origin, int unsigned req,
                                  output int unsigned st, output int unsigned runs);
    int unsigned p, len;
    p = origin; len = 0; st = 0; runs = 0;
    for (int k = 0; k < UNITS; k++) begin
      if (cells[p] == 0) begin
        if (len == 0 || k == 0 || p == 0) begin
          st = p; len = 0; runs++;
        end
        len++;
        if (len >= req) return 1;
      end else len = 0;
      p = (p + 1 == UNITS) ? 0 : p + 1;
    end
    return 0;
  endfunction

  function automatic bit best_fit(int unsigned req, output int unsigned st,
                                  output int unsigned runs);
    int unsigned len, cur, best_len;
    bit found;
    len = 0; cur = 0; runs = 0; best_len = 0; st = 0; found = 0;
    for (int i = 0; i <= UNITS; i++) begin
      if (i < UNITS && cells[i] == 0) begin
        if (len == 0) begin
          cur = i; runs++;
        end
        len++;
      end else begin
        if (len >= req && (!found || len < best_len)) begin
          found = 1; best_len = len; st = cur;
        end
        len = 0;
      end
    end
    return found;
  endfunction

  function automatic outcome_t predict_outcome(cmd_t c);
    outcome_t o;
    int unsigned st, runs, len, fr;
    bit ok;
    o = '{1'b0, 8'd0, 8'd0};
    st = 0; runs = 0; ok = 0;
    case (c.kind)
      cpa_pkg::KIND_ALLOC: begin
        if (c.req != 0 && c.strat != cpa_pkg::STRAT_NONE) begin
          if (c.strat == cpa_pkg::STRAT_FIRST) ok = scan_fit(0, c.req, st, runs);
          else if (c.strat == cpa_pkg::STRAT_BEST) ok = best_fit(c.req, st, runs);
          else ok = scan_fit(resume_pos, c.req, st, runs);
          if (ok) begin
            for (int i = 0; i < c.req && st + i < UNITS; i++) cells[st + i] = c.life;
            if (c.strat == cpa_pkg::STRAT_NEXT) resume_pos = (st + c.req) % UNITS;
          end
          o.placed = ok;
          o.probed = sat8(runs);
        end
      end
      cpa_pkg::KIND_TICK: for (int i = 0; i < UNITS; i++) if (cells[i] != 0) cells[i]--;
      cpa_pkg::KIND_CLEAR: for (int i = 0; i < UNITS; i++) cells[i] = 0;
      default: begin
        len = 0; fr = 0;
        for (int i = 0; i <= UNITS; i++) begin
          if (i < UNITS && cells[i] == 0) len++;
          else begin
            if (len != 0 && len <= c.limit) fr++;
            len = 0;
          end
        end
        o.frags = sat8(fr);
      end
    endcase
    return o;
  endfunction

  function automatic cmd_t mk(cpa_pkg::kind_e k, cpa_pkg::strat_e s, int r, int l, int f);
    cmd_t c;
    c.kind = k; c.strat = s; c.req = r[8:0]; c.life = l[7:0]; c.limit = f[8:0];
    c.drain = 0;
    return c;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int r;
    r = $urandom_range(0, 99);
    c = mk(cpa_pkg::KIND_ALLOC, cpa_pkg::strat_e'($urandom_range(0, 2)), 1,
           $urandom_range(1, 255), $urandom_range(0, 511));
    if (r < 60) begin
      if ($urandom_range(0, 9) == 0) c.req = 9'($urandom_range(0, 511));
      else if ($urandom_range(0, 3) == 0) c.req = 9'($urandom_range(1, 128));
      else c.req = 9'($urandom_range(1, 16));
      if ($urandom_range(0, 3) == 0) c.life = 8'($urandom_range(0, 255));
      else c.life = 8'($urandom_range(1, 8));
      if ($urandom_range(0, 19) == 0) c.strat = cpa_pkg::STRAT_NONE;
    end else if (r < 85) c.kind = cpa_pkg::KIND_TICK;
    else if (r < 88) c.kind = cpa_pkg::KIND_CLEAR;
    else begin
      c.kind = cpa_pkg::KIND_FRAG;
      c.strat = cpa_pkg::strat_e'($urandom_range(0, 3));
      c.req = 9'($urandom_range(0, 511));
    end
    return c;
  endfunction

  // driver
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (start_i && !busy_o) begin
      start_i <= 1'b0;
    end else if (!start_i && rst_ni) begin
      if (gap > 0) gap <= gap - 1;
      else if (pending_cmds.size() != 0 &&
               !(pending_cmds[0].drain && expected_outcomes.size() != 0)) begin
        cmd_t c;
        c = pending_cmds.pop_front();
        expected_outcomes.push_back(predict_outcome(c));
        start_i <= 1'b1;
        kind_i <= c.kind;
        strategy_i <= c.strat;
        request_units_i <= c.req;
        lifetime_i <= c.life;
        fragment_limit_i <= c.limit;
        if (!quiet && $urandom_range(0, 3) == 0) gap <= $urandom_range(1, 16);
      end else if (pending_cmds.size() == 0) stim_done <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (valid_o) begin
      if (expected_outcomes.size() == 0) begin
        $error("unexpected result");
        errors++;
      end else begin
        outcome_t e;
        e = expected_outcomes.pop_front();
        if (placed_o !== e.placed) begin
          $error("placed exp %0d act %0d", e.placed, placed_o);
          errors++;
        end
        if (runs_probed_o !== e.probed) begin
          $error("runs_probed exp %0d act %0d", e.probed, runs_probed_o);
          errors++;
        end
        if (fragment_total_o !== e.frags) begin
          $error("fragment_total exp %0d act %0d", e.frags, fragment_total_o);
          errors++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    cmd_t c;
    for (int i = 0; i < UNITS; i++) cells[i] = 0;
    resume_pos = 0;
    pending_cmds.push_back(mk(cpa_pkg::KIND_FRAG, cpa_pkg::STRAT_FIRST, 0, 0, 256));
    pending_cmds.push_back(mk(cpa_pkg::KIND_FRAG, cpa_pkg::STRAT_FIRST, 0, 0, 0));
    pending_cmds.push_back(mk(cpa_pkg::KIND_ALLOC, cpa_pkg::STRAT_FIRST, 0, 5, 0));
    pending_cmds.push_back(mk(cpa_pkg::KIND_ALLOC, cpa_pkg::STRAT_NONE, 4, 5, 0));
    pending_cmds.push_back(mk(cpa_pkg::KIND_ALLOC, cpa_pkg::STRAT_FIRST, 300, 5, 0));
    pending_cmds.push_back(mk(cpa_pkg::KIND_ALLOC, cpa_pkg::STRAT_FIRST, 511, 255, 511));
    pending_cmds.push_back(mk(cpa_pkg::KIND_ALLOC, cpa_pkg::STRAT_NEXT, 10, 3, 0));
    pending_cmds.push_back(mk(cpa_pkg::KIND_ALLOC, cpa_pkg::STRAT_FIRST, 5, 1, 0));
    pending_cmds.push_back(mk(cpa_pkg::KIND_ALLOC, cpa_pkg::STRAT_BEST, 2, 255, 0));
    pending_cmds.push_back(mk(cpa_pkg::KIND_ALLOC, cpa_pkg::STRAT_NEXT, 240, 2, 0));
    pending_cmds.push_back(mk(cpa_pkg::KIND_ALLOC, cpa_pkg::STRAT_NEXT, 20, 2, 0));
    pending_cmds.push_back(mk(cpa_pkg::KIND_FRAG, cpa_pkg::STRAT_BEST, 0, 0, 1));
    pending_cmds.push_back(mk(cpa_pkg::KIND_TICK, cpa_pkg::STRAT_NONE, 511, 255, 511));
    pending_cmds.push_back(mk(cpa_pkg::KIND_ALLOC, cpa_pkg::STRAT_BEST, 1, 0, 0));
    pending_cmds.push_back(mk(cpa_pkg::KIND_FRAG, cpa_pkg::STRAT_FIRST, 0, 0, 3));
    pending_cmds.push_back(mk(cpa_pkg::KIND_CLEAR, cpa_pkg::STRAT_FIRST, 0, 0, 0));
    pending_cmds.push_back(mk(cpa_pkg::KIND_ALLOC, cpa_pkg::STRAT_NEXT, 256, 170, 0));
    pending_cmds.push_back(mk(cpa_pkg::KIND_ALLOC, cpa_pkg::STRAT_BEST, 256, 85, 0));
    pending_cmds.push_back(mk(cpa_pkg::KIND_TICK, cpa_pkg::STRAT_FIRST, 0, 0, 0));
    pending_cmds.push_back(mk(cpa_pkg::KIND_CLEAR, cpa_pkg::STRAT_FIRST, 0, 0, 0));
    for (int i = 0; i < 1130; i++) begin
      c = random_cmd();
      if (i == 500) c.drain = 1;
      pending_cmds.push_back(c);
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_cmds.size() < 150);
    quiet = 1;
    wait (stim_done && expected_outcomes.size() == 0);
    repeat (1200) @(posedge clk_i);
    if (errors == 0 && expected_outcomes.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
`default_nettype wire
